// ===== hw/rtl/sgdmu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum update package
// Shared widths, parameter defaults and register codes for the SGD update unit.
// ----------------------------------------------------------------------------
package sgdmu_pkg;

	// Widths of the fixed fields of an item.
	localparam int Q_W       = 32;
	localparam int IDX_W     = 12;
	localparam int CFG_IDX_W = 2;
	// Wide enough for a saturated value plus a shifted full product.
	localparam int SUM_W     = 2 * Q_W + 2;

	// Defaults for the parameters of the top level.
	localparam int DEF_ELEMENT_COUNT = 4096;
	localparam int DEF_VALUE_WIDTH   = 32;
	localparam int DEF_FRACTION_BITS = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE   = 2'd0,
		REG_MOMENTUM_FACTOR = 2'd1,
		REG_WEIGHT_DECAY    = 2'd2,
		REG_USE_NESTEROV    = 2'd3
	} cfg_reg_t;

endpackage

// ===== hw/rtl/sgdmu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module sgdmu_ram
	import sgdmu_pkg::*;
#(
	parameter int WIDTH = DEF_VALUE_WIDTH,
	parameter int DEPTH = DEF_ELEMENT_COUNT,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/sgd_momentum_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum update unit
// Element-wise SGD step with weight decay, momentum and Nesterov momentum in
// signed fixed point, with a per-element velocity RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------------------------------------
//  config   | cfg_write             | cfg_index, cfg_data
//  input    | in_valid / in_stall   | element_index, weight_value, gradient_value, gradient_present
//  output   | out_valid / out_stall | out_index, new_weight, effective_gradient, was_updated
//
//  One transaction per cycle is accepted in steady state, unless the output stall or
//  the velocity interlock holds the input; results leave through the output register.
//  With a non-zero momentum factor, an item carrying a gradient that directly
//  follows another such item for the same element waits for the velocity loop.
//  After reset a clearing pass zeroes every entry of the velocity RAM with
//  in_stall high; later the pipeline freezes only while stage 7 and the stalled output hold results.
//
module sgd_momentum_update_unit
	import sgdmu_pkg::*;
#(
	parameter int ELEMENT_COUNT = DEF_ELEMENT_COUNT,
	parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [IDX_W-1:0]     element_index,
	input  logic signed [Q_W-1:0] weight_value,
	input  logic signed [Q_W-1:0] gradient_value,
	input  logic                 gradient_present,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     out_index,
	output logic signed [Q_W-1:0] new_weight,
	output logic signed [Q_W-1:0] effective_gradient,
	output logic                 was_updated
);

	// Saturation width: the value fields never exceed 32 bits.
	localparam int SAT_W  = (VALUE_WIDTH < Q_W) ? VALUE_WIDTH : Q_W;
	localparam int ADDR_W = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(ELEMENT_COUNT - 1);
	localparam logic [Q_W-1:0] ELEM_LIMIT = Q_W'(ELEMENT_COUNT);
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		(SUM_W'(1) <<< (SAT_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

	// Fields of an item that travel alongside the arithmetic.
	typedef struct packed {
		logic [IDX_W-1:0]      idx;
		logic signed [Q_W-1:0] w;
		logic signed [Q_W-1:0] g;
		logic                  present;
		logic                  in_range;
	} meta_t;

	// Clamp a wide sum to the signed range of SAT_W bits.
	function automatic logic signed [Q_W-1:0] sat_fn(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] r;
		r = x;
		if (x > SAT_MAX) begin
			r = SAT_MAX;
		end else if (x < SAT_MIN) begin
			r = SAT_MIN;
		end
		return r[Q_W-1:0];
	endfunction

	// Drop the fraction bits of a full product, rounding towards minus infinity.
	function automatic logic signed [SUM_W-1:0] fx_fn(input logic signed [2*Q_W-1:0] p);
		return SUM_W'(p >>> FRACTION_BITS);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [Q_W-1:0] lr_q, mu_q, wd_q;
	logic                  nest_q;
	logic                  mu_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= '0;
			mu_q   <= '0;
			wd_q   <= '0;
			nest_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEARNING_RATE:   lr_q   <= cfg_data;
				REG_MOMENTUM_FACTOR: mu_q   <= cfg_data;
				REG_WEIGHT_DECAY:    wd_q   <= cfg_data;
				REG_USE_NESTEROV:    nest_q <= cfg_data[0];
			endcase
		end
	end

	// A zero momentum factor bypasses the velocity RAM entirely.
	assign mu_nz = |mu_q;

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	meta_t       meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;
	meta_t       in_meta;
	logic        out_valid_q;
	logic        advance;
	logic        hazard;
	logic        accept;
	logic        clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// The whole pipeline moves together unless a finished result in the last
	// stage has nowhere to go.
	assign advance = !(valid_s7 && out_valid_q && out_stall);

	// An item for the element that has just entered stage 1 would reach the
	// velocity multiplier before that element's new velocity is registered;
	// hold it back while that element is still in stage 1.
	assign hazard = valid_s1 && meta_s1.present && gradient_present && mu_nz &&
		(meta_s1.idx == element_index);

	assign in_stall = clearing_q || !advance || hazard;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		in_meta.idx      = element_index;
		in_meta.w        = weight_value;
		in_meta.g        = gradient_value;
		in_meta.present  = gradient_present;
		in_meta.in_range = {{(Q_W - IDX_W){1'b0}}, element_index} < ELEM_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Clearing pass after reset: one velocity entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	logic signed [Q_W-1:0]   w_sat_s1;
	logic signed [2*Q_W-1:0] pwd_s1, pwd_s2;
	logic signed [Q_W-1:0]   g1_s2, g1_s3, g1_s4, g1_s5;
	logic signed [Q_W-1:0]   v_old_s2;
	logic signed [2*Q_W-1:0] pmv_s2, pmv_s3;
	logic signed [Q_W-1:0]   v_new_s3, v_s4, v_s5;
	logic                    wr_s4;
	logic signed [2*Q_W-1:0] pn_s4, pn_s5;
	logic signed [Q_W-1:0]   g2_s5, g2_s6, g2_s7;
	logic signed [2*Q_W-1:0] plr_s6, plr_s7;
	logic signed [Q_W-1:0]   nw_s7;
	logic                    fwd_s2;
	logic                    wr_now;
	logic signed [SAT_W-1:0] ram_rdata;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [SAT_W-1:0]        ram_wdata;
	logic                    ram_we;

	// Stage 1: weight decay product; velocity read is issued.
	assign w_sat_s1 = sat_fn(SUM_W'(meta_s1.w));
	assign pwd_s1   = wd_q * w_sat_s1;

	// Stage 2: decayed gradient and the momentum product. The element two
	// stages ahead has written its velocity at the same edge as this read,
	// so its registered value is forwarded.
	assign g1_s2  = sat_fn(SUM_W'(sat_fn(SUM_W'(meta_s2.g))) + fx_fn(pwd_s2));
	assign fwd_s2 = valid_s4 && wr_s4 && (meta_s4.idx == meta_s2.idx);

	always_comb begin
		if (!meta_s2.in_range) begin
			v_old_s2 = '0;
		end else if (fwd_s2) begin
			v_old_s2 = v_s4;
		end else begin
			v_old_s2 = Q_W'(ram_rdata);
		end
	end

	assign pmv_s2 = mu_q * v_old_s2;

	// Stage 3: new velocity, written back to the RAM.
	assign v_new_s3 = sat_fn(SUM_W'(g1_s3) + fx_fn(pmv_s3));
	assign wr_now   = advance && valid_s3 && meta_s3.present && meta_s3.in_range && mu_nz;

	// Stage 4: Nesterov look-ahead product.
	assign pn_s4 = v_s4 * mu_q;

	// Stage 5: effective gradient.
	always_comb begin
		if (!mu_nz) begin
			g2_s5 = g1_s5;
		end else if (nest_q) begin
			g2_s5 = sat_fn(SUM_W'(g1_s5) + fx_fn(pn_s5));
		end else begin
			g2_s5 = v_s5;
		end
	end

	// Stage 6: learning rate product.
	assign plr_s6 = lr_q * g2_s6;

	// Stage 7: new weight.
	assign nw_s7 = sat_fn(SUM_W'(sat_fn(SUM_W'(meta_s7.w))) - fx_fn(plr_s7));

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1 <= in_meta;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
			pwd_s2  <= pwd_s1;
			g1_s3   <= g1_s2;
			pmv_s3  <= pmv_s2;
			g1_s4   <= g1_s3;
			v_s4    <= v_new_s3;
			wr_s4   <= valid_s3 && meta_s3.present && meta_s3.in_range && mu_nz;
			g1_s5   <= g1_s4;
			v_s5    <= v_s4;
			pn_s5   <= pn_s4;
			g2_s6   <= g2_s5;
			g2_s7   <= g2_s6;
			plr_s7  <= plr_s6;
		end
	end

	// ------------------------------------------------------------------
	// Velocity RAM
	// ------------------------------------------------------------------
	assign ram_we    = clearing_q || wr_now;
	assign ram_waddr = clearing_q ? clr_addr_q : ADDR_W'(meta_s3.idx);
	assign ram_wdata = clearing_q ? '0 : v_new_s3[SAT_W-1:0];

	sgdmu_ram #(
		.WIDTH (SAT_W),
		.DEPTH (ELEMENT_COUNT)
	) u_vel_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (advance),
		.raddr (ADDR_W'(meta_s1.idx)),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]      out_index_q;
	logic signed [Q_W-1:0] new_weight_q;
	logic signed [Q_W-1:0] eff_grad_q;
	logic                  was_updated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s7 && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Without a gradient the item passes through untouched.
	always_ff @(posedge clk) begin
		if (valid_s7 && advance) begin
			out_index_q   <= meta_s7.idx;
			new_weight_q  <= meta_s7.present ? nw_s7 : meta_s7.w;
			eff_grad_q    <= meta_s7.present ? g2_s7 : meta_s7.g;
			was_updated_q <= meta_s7.present;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_index          = out_index_q;
	assign new_weight         = new_weight_q;
	assign effective_gradient = eff_grad_q;
	assign was_updated        = was_updated_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The interlock keeps two updates of one element out of adjacent stages.
	a_no_adjacent_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && valid_s3 && meta_s2.present && meta_s3.present && mu_nz &&
		  meta_s2.idx == meta_s3.idx))
		else $error("velocity update of one element in adjacent stages");

	a_stall_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> in_stall)
		else $error("input accepted during the velocity clearing pass");

	a_empty_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !(valid_s1 || valid_s2 || valid_s3))
		else $error("pipeline busy during the velocity clearing pass");

	a_forward_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && fwd_s2) |-> meta_s2.in_range)
		else $error("velocity forwarded to an element outside the store");

	a_result_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && advance) |=> out_valid_q)
		else $error("result from the last stage lost");

endmodule
